/* rtl/core/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// shared types and constants of the free page stack allocator
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int PageW   = 13;
  localparam int LinkW   = 14;
  localparam int FuncW   = 2;
  localparam int StatusW = 2;

  localparam logic [LinkW-1:0] FloorReset = 14'h1000;

  typedef enum logic [FuncW-1:0] {
    FUNC_LINK = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PUSH = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LINK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [PageW-1:0] region_start;
    logic [LinkW-1:0] region_end;
    logic             region_usable;
    logic [PageW-1:0] page_in;
  } req_t;

  typedef struct packed {
    logic [PageW-1:0] page_out;
    status_e          status;
  } rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

/* rtl/core/fps_link_mem.sv */
// ----------------------------------------------------------------------------
// fps_link_mem
// next-link table, one write port and one registered read port
// ----------------------------------------------------------------------------
module fps_link_mem import fps_pkg::*; #(
  parameter int Depth = 8193,
  parameter int AW    = 14
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [LinkW-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [LinkW-1:0] rdata_o
);

  logic [LinkW-1:0] mem_q [Depth];
  logic [LinkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fps_ctrl.sv */
// ----------------------------------------------------------------------------
// fps_ctrl
// request sequencer: head and tail of the chain, floor register, link walk
// ----------------------------------------------------------------------------
module fps_ctrl import fps_pkg::*; #(
  parameter  int NUM_PAGES = 8192,
  localparam int AW        = $clog2(NUM_PAGES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LinkW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  input  logic             out_free_i,
  output logic             res_load_o,
  output rsp_t             res_o,
  output mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [LinkW-1:0] mem_wdata_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  logic [LinkW-1:0] mem_rdata_i
);

  localparam int CW = (AW > LinkW) ? AW : LinkW;
  localparam logic [CW-1:0] NumPagesC = CW'(NUM_PAGES);

  function automatic logic [AW-1:0] to_addr(logic [LinkW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return AW'(w);
  endfunction

  state_e           state_q, state_d;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] tail_q, tail_d;
  logic [LinkW-1:0] floor_q;
  logic [LinkW-1:0] p_q, p_d;
  rsp_t             res_q, res_d;

  logic             accept;
  logic [LinkW-1:0] rs_ext, pin_ext, eff_start, end_clamp, p_next;
  logic             link_ok, head_ok, push_ok;
  logic             fin, go_pop, go_link;
  rsp_t             fin_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign rs_ext    = LinkW'(in_req_i.region_start);
  assign pin_ext   = LinkW'(in_req_i.page_in);
  assign eff_start = (rs_ext < floor_q) ? floor_q : rs_ext;
  assign end_clamp = (CW'(in_req_i.region_end) > NumPagesC) ?
                     LinkW'(NumPagesC) : in_req_i.region_end;
  assign link_ok   = in_req_i.region_usable && (eff_start < end_clamp);
  assign head_ok   = (head_q != tail_q) && (CW'(head_q) < NumPagesC);
  assign push_ok   = CW'(pin_ext) < NumPagesC;
  assign p_next    = p_q + LinkW'(1);

  // datapath and result
  always_comb begin
    mem_ctl_o   = '0;
    mem_waddr_o = to_addr(tail_q);
    mem_wdata_o = eff_start;
    mem_raddr_o = to_addr(head_q);
    head_d      = head_q;
    tail_d      = tail_q;
    p_d         = p_q;
    fin         = 1'b0;
    go_pop      = 1'b0;
    go_link     = 1'b0;
    fin_rsp     = '{page_out: '0, status: ST_DONE};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req_i.func)
            FUNC_LINK: begin
              if (link_ok) begin
                mem_ctl_o.we = 1'b1;
                if (head_q == tail_q) begin
                  head_d = eff_start;
                end
                tail_d  = end_clamp;
                p_d     = eff_start;
                go_link = 1'b1;
              end else begin
                fin            = 1'b1;
                fin_rsp.status = ST_IGNORED;
              end
            end
            FUNC_POP: begin
              if (head_ok) begin
                mem_ctl_o.re = 1'b1;
                go_pop       = 1'b1;
              end else begin
                fin            = 1'b1;
                fin_rsp.status = ST_EMPTY;
              end
            end
            FUNC_PUSH: begin
              fin = 1'b1;
              if (push_ok) begin
                mem_ctl_o.we = 1'b1;
                mem_waddr_o  = to_addr(pin_ext);
                mem_wdata_o  = head_q;
                head_d       = pin_ext;
              end else begin
                fin_rsp.status = ST_IGNORED;
              end
            end
            default: begin
              fin            = 1'b1;
              fin_rsp.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_POP: begin
        fin              = 1'b1;
        fin_rsp.page_out = head_q[PageW-1:0];
        head_d           = mem_rdata_i;
      end
      S_LINK: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = to_addr(p_q);
        mem_wdata_o  = p_next;
        p_d          = p_next;
        fin          = (p_next == tail_q);
      end
      S_RESP: begin
        fin = 1'b0;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign res_load_o = out_free_i && (fin || (state_q == S_RESP));
  assign res_o      = (state_q == S_RESP) ? res_q : fin_rsp;
  assign res_d      = (fin && !out_free_i) ? fin_rsp : res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_pop) begin
          state_d = S_POP;
        end else if (go_link) begin
          state_d = S_LINK;
        end else if (fin && !out_free_i) begin
          state_d = S_RESP;
        end
      end
      S_POP, S_LINK: begin
        if (fin) begin
          state_d = out_free_i ? S_IDLE : S_RESP;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      floor_q <= FloorReset;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg_we_i) begin
        floor_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    res_q <= res_d;
  end

endmodule

/* rtl/core/free_page_stack_top.sv */
// ----------------------------------------------------------------------------
// free_page_stack_top
// page allocator kept as a linked free stack in a next-link memory
// ----------------------------------------------------------------------------
// request channel: in_valid_i / in_stall_o with in_req_i; one request is taken
// at a time, in_stall_o stays high until the current request has finished.
// response channel: out_valid_o / out_stall_i with out_rsp_o; every request
// gives exactly one response, held in an output register while stalled.
// push, ignored requests and pop on an empty chain finish in the cycle they
// are taken; pop finishes in the next cycle, once the next-link memory read
// has returned; linking a region writes one link per cycle through the single
// memory write port, from the start clamped to the floor up to the clamped end.
// a new request is taken while a response still waits in the output
// register; if a second one finishes before that register drains, it is held
// and the block stalls its input until the response is delivered.
// the user writes floor_page through cfg_we_i / cfg_wdata_i only while idle;
// the block does not enforce this. reset clears head, tail and out_valid_o
// and sets the floor to page 4096; the next-link memory is not cleared.
// ----------------------------------------------------------------------------
module free_page_stack_top import fps_pkg::*; #(
  parameter int NUM_PAGES = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LinkW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o
);

  localparam int AW = $clog2(NUM_PAGES + 1);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [LinkW-1:0] mem_wdata, mem_rdata;
  logic             out_free, res_load;
  rsp_t             res;
  logic             out_valid_q;
  rsp_t             out_rsp_q;

  assign out_free = !out_valid_q || !out_stall_i;

  fps_ctrl #(
    .NUM_PAGES (NUM_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fps_link_mem #(
    .Depth (NUM_PAGES + 1),
    .AW    (AW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
